// File: rtl/equirect_depth_unproject_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the equirectangular depth unprojection core
// Clocked implication checks with an active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef EQUIRECT_DEPTH_UNPROJECT_CORE_ASSERT_SVH
`define EQUIRECT_DEPTH_UNPROJECT_CORE_ASSERT_SVH

// Same-cycle implication
`define EQDU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("%m: property violated");

// Next-cycle implication
`define EQDU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("%m: property violated");

`endif

// File: rtl/eqdu_pkg.sv
// ---------------------------------------------------------------------------
// eqdu_pkg
// Types, constants and elaboration-time trig helpers for the unprojection core.
// ---------------------------------------------------------------------------
package eqdu_pkg;

	localparam int PANO_WIDTH_DEF  = 512;
	localparam int PANO_HEIGHT_DEF = 256;

	localparam int COLUMN_W   = 9;
	localparam int ROW_W      = 8;
	localparam int DEPTH_W    = 16;
	localparam int COLOR_W    = 8;
	localparam int WORLD_W    = 32;
	localparam int SPLAT_W    = 12;
	localparam int ROT_W      = 54;
	localparam int COEF_W     = 18;
	localparam int TRIG_W     = 17;
	localparam int CAM_W      = 18;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;
	localparam int NUM_STAGES = 7;

	localparam logic [SPLAT_W-1:0] SPLAT_MAX      = 12'd3277;
	localparam logic [DEPTH_W-1:0] DEPTH_FLOOR_RST = 16'd25;
	localparam logic [DEPTH_W-1:0] DEPTH_CEIL_RST  = 16'd25600;

	typedef longint unsigned u64_t;

	localparam u64_t Q30_ONE     = 64'd1073741824;
	localparam u64_t HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [2:0] {
		REG_ROT_X,
		REG_ROT_Y,
		REG_ROT_Z,
		REG_TRANS_X,
		REG_TRANS_Y,
		REG_TRANS_Z,
		REG_DEPTH_FLOOR,
		REG_DEPTH_CEIL
	} cfg_reg_t;

	typedef struct packed {
		logic [COLUMN_W-1:0] column;
		logic [ROW_W-1:0]    row;
		logic [DEPTH_W-1:0]  depth;
		logic [COLOR_W-1:0]  blue;
		logic [COLOR_W-1:0]  green;
		logic [COLOR_W-1:0]  red;
	} pixel_t;

	typedef struct packed {
		logic signed [WORLD_W-1:0] world_x;
		logic signed [WORLD_W-1:0] world_y;
		logic signed [WORLD_W-1:0] world_z;
		logic [SPLAT_W-1:0]        splat_size;
		logic [COLOR_W-1:0]        out_red;
		logic [COLOR_W-1:0]        out_green;
		logic [COLOR_W-1:0]        out_blue;
	} point_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] sn;
		logic signed [TRIG_W-1:0] cs;
	} trig_t;

	typedef struct packed {
		logic signed [CAM_W-1:0] x;
		logic signed [CAM_W-1:0] y;
		logic signed [CAM_W-1:0] z;
	} cam_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} color_t;

	// Taylor series in Q30 radians; odd picks sine, else cosine.
	function automatic u64_t taylor_q30(input u64_t x, input logic odd);
		u64_t x2;
		u64_t term;
		u64_t sum;
		u64_t p;
		int   last;
		x2   = (x * x) >> 30;
		term = odd ? x : Q30_ONE;
		sum  = term;
		last = odd ? 4 : 5;
		for (int k = 1; k <= last; k++) begin
			p = (term * x2) >> 30;
			if (odd) begin
				case (k)
					1:       term = p / 6;
					2:       term = p / 20;
					3:       term = p / 42;
					default: term = p / 72;
				endcase
			end else begin
				case (k)
					1:       term = p / 2;
					2:       term = p / 12;
					3:       term = p / 30;
					4:       term = p / 56;
					default: term = p / 90;
				endcase
			end
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	function automatic logic signed [TRIG_W-1:0] to_q15(input u64_t v);
		return TRIG_W'((v + 64'd16384) >> 15);
	endfunction

	// Sine and cosine of an angle given in turns, Q32, via first-octant fold.
	function automatic trig_t sin_cos_turn(input logic [31:0] t);
		u64_t                     r;
		u64_t                     x;
		logic signed [TRIG_W-1:0] s;
		logic signed [TRIG_W-1:0] c;
		trig_t                    res;
		r = u64_t'(t[29:0]);
		if (r <= (Q30_ONE >> 1)) begin
			x = (r * HALF_PI_Q30) >> 30;
			s = to_q15(taylor_q30(x, 1'b1));
			c = to_q15(taylor_q30(x, 1'b0));
		end else begin
			x = ((Q30_ONE - r) * HALF_PI_Q30) >> 30;
			s = to_q15(taylor_q30(x, 1'b0));
			c = to_q15(taylor_q30(x, 1'b1));
		end
		unique case (t[31:30])
			2'd0: begin res.sn = s;  res.cs = c;  end
			2'd1: begin res.sn = c;  res.cs = -s; end
			2'd2: begin res.sn = -s; res.cs = -c; end
			default: begin res.sn = -c; res.cs = s; end
		endcase
		return res;
	endfunction

endpackage

// File: rtl/eqdu_trig_rom.sv
// ---------------------------------------------------------------------------
// eqdu_trig_rom
// Longitude and latitude sine/cosine tables, indexed by raw column and row,
// with registered read.
// ---------------------------------------------------------------------------
module eqdu_trig_rom #(
	parameter int PANO_WIDTH  = eqdu_pkg::PANO_WIDTH_DEF,
	parameter int PANO_HEIGHT = eqdu_pkg::PANO_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [eqdu_pkg::COLUMN_W-1:0] column,
	input  logic [eqdu_pkg::ROW_W-1:0]    row,
	output eqdu_pkg::trig_t               lon_s1,
	output eqdu_pkg::trig_t               lat_s1
);
	import eqdu_pkg::*;

	localparam int LON_DEPTH = 2 ** COLUMN_W;
	localparam int LAT_DEPTH = 2 ** ROW_W;
	localparam int LAT_DIV   = 2 * PANO_HEIGHT;

	trig_t lon_rom [LON_DEPTH];
	trig_t lat_rom [LAT_DEPTH];

	// Column wraps modulo the panorama width.
	for (genvar i = 0; i < LON_DEPTH; i++) begin : g_lon
		localparam u64_t LonNum = (u64_t'(i % PANO_WIDTH) << 32) + u64_t'(PANO_WIDTH / 2);
		localparam u64_t LonQ   = LonNum / PANO_WIDTH;
		localparam logic [31:0] LonTurn = 32'(LonQ - 64'h8000_0000);
		assign lon_rom[i] = sin_cos_turn(LonTurn);
	end

	// Row clamps to the last panorama row.
	for (genvar i = 0; i < LAT_DEPTH; i++) begin : g_lat
		localparam int   RowC   = (i >= PANO_HEIGHT) ? PANO_HEIGHT - 1 : i;
		localparam u64_t LatNum = (u64_t'(RowC) << 32) + u64_t'(PANO_HEIGHT);
		localparam u64_t LatQ   = LatNum / LAT_DIV;
		localparam logic [31:0] LatTurn = 32'(64'h4000_0000 - LatQ);
		assign lat_rom[i] = sin_cos_turn(LatTurn);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lon_s1 <= lon_rom[column];
			lat_s1 <= lat_rom[row];
		end
	end

endmodule

// File: rtl/eqdu_ray_scale.sv
// ---------------------------------------------------------------------------
// eqdu_ray_scale
// Build the camera ray, scale it by depth and compute the splat scale.
// Stages 2 to 4.
// ---------------------------------------------------------------------------
module eqdu_ray_scale (
	input  logic                         clk,
	input  logic [2:0]                   stage_en,
	input  logic [eqdu_pkg::DEPTH_W-1:0] depth_s1,
	input  eqdu_pkg::trig_t              lon_s1,
	input  eqdu_pkg::trig_t              lat_s1,
	output eqdu_pkg::cam_t               cam_s4,
	output logic [eqdu_pkg::SPLAT_W-1:0] splat_s4
);
	import eqdu_pkg::*;

	localparam int RAY_W  = 32;
	localparam int PROD_W = DEPTH_W + 1 + RAY_W;
	localparam int QTR_W  = DEPTH_W - 1;
	localparam int SPL_PW = QTR_W + 16;
	localparam logic [15:0] RECIP_FIVE = 16'd52429;
	localparam logic signed [PROD_W-1:0] HALF_Q30 = PROD_W'(64'd536870912);

	logic signed [RAY_W-1:0]  dx_s2, dy_s2, dz_s2;
	logic [DEPTH_W-1:0]       depth_s2;
	logic [QTR_W-1:0]         quarter_s2;
	logic signed [PROD_W-1:0] px_s3, py_s3, pz_s3;
	logic [SPL_PW-1:0]        spl_s3;
	logic [DEPTH_W:0]         dep_bias;
	logic signed [PROD_W-1:0] rx, ry, rz;
	logic signed [DEPTH_W:0]  depth_sx;

	assign dep_bias = {1'b0, depth_s1} + (DEPTH_W+1)'(10);
	assign depth_sx = $signed({1'b0, depth_s2});
	assign rx = px_s3 + HALF_Q30;
	assign ry = py_s3 + HALF_Q30;
	assign rz = pz_s3 + HALF_Q30;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			dx_s2      <= RAY_W'(lat_s1.cs * lon_s1.sn);
			dz_s2      <= RAY_W'(lat_s1.cs * lon_s1.cs);
			dy_s2      <= -($signed({{(RAY_W-TRIG_W){lat_s1.sn[TRIG_W-1]}}, lat_s1.sn}) <<< 15);
			depth_s2   <= depth_s1;
			quarter_s2 <= dep_bias[DEPTH_W:2];
		end
		if (stage_en[1]) begin
			px_s3  <= depth_sx * dx_s2;
			py_s3  <= depth_sx * dy_s2;
			pz_s3  <= depth_sx * dz_s2;
			spl_s3 <= quarter_s2 * RECIP_FIVE;
		end
		// Drop the fraction of the camera coordinates with round-half-up; the splat scale is truncated
		if (stage_en[2]) begin
			cam_s4.x <= rx[30 +: CAM_W];
			cam_s4.y <= ry[30 +: CAM_W];
			cam_s4.z <= rz[30 +: CAM_W];
			splat_s4 <= spl_s3[18 +: SPLAT_W];
		end
	end

endmodule

// File: rtl/eqdu_world_xform.sv
// ---------------------------------------------------------------------------
// eqdu_world_xform
// Rotate the camera point into world space, translate and saturate.
// Stages 5 to 7.
// ---------------------------------------------------------------------------
module eqdu_world_xform (
	input  logic                                clk,
	input  logic [2:0]                          stage_en,
	input  eqdu_pkg::cam_t                      cam_s4,
	input  logic [eqdu_pkg::ROT_W-1:0]          rot [3],
	input  logic signed [eqdu_pkg::WORLD_W-1:0] trans [3],
	output logic signed [eqdu_pkg::WORLD_W-1:0] world_s7 [3]
);
	import eqdu_pkg::*;

	localparam int MUL_W = COEF_W + CAM_W;
	localparam int ACC_W = MUL_W + 2;
	localparam int SHR   = 15;
	localparam int SH_W  = ACC_W - SHR;
	localparam int SUM_W = WORLD_W + 1;

	logic signed [CAM_W-1:0] cam_v [3];
	logic signed [MUL_W-1:0] prod_s5 [3][3];
	logic signed [SH_W-1:0]  acc_s6 [3];
	logic signed [ACC_W-1:0] acc_rnd [3];
	logic signed [SUM_W-1:0] sum_t [3];
	logic signed [WORLD_W-1:0] sat [3];

	assign cam_v[0] = cam_s4.x;
	assign cam_v[1] = cam_s4.y;
	assign cam_v[2] = cam_s4.z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			acc_rnd[a] = ACC_W'(prod_s5[a][0]) + ACC_W'(prod_s5[a][1])
			           + ACC_W'(prod_s5[a][2]) + ACC_W'(1 << (SHR - 1));
			sum_t[a] = SUM_W'(acc_s6[a]) + SUM_W'(trans[a]);
			if (sum_t[a][SUM_W-1] != sum_t[a][SUM_W-2]) begin
				sat[a] = sum_t[a][SUM_W-1] ? {1'b1, {(WORLD_W-1){1'b0}}}
				                           : {1'b0, {(WORLD_W-1){1'b1}}};
			end else begin
				sat[a] = sum_t[a][WORLD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (stage_en[0]) begin
				for (int j = 0; j < 3; j++) begin
					prod_s5[a][j] <= $signed(rot[a][COEF_W*j +: COEF_W]) * cam_v[j];
				end
			end
			if (stage_en[1]) begin
				acc_s6[a] <= acc_rnd[a][ACC_W-1:SHR];
			end
			if (stage_en[2]) begin
				world_s7[a] <= sat[a];
			end
		end
	end

endmodule

// File: rtl/equirect_depth_unproject_core.sv
// ---------------------------------------------------------------------------
// equirect_depth_unproject_core
// Turn equirectangular depth/colour pixels into world-space splat points.
// ---------------------------------------------------------------------------
//
//  Channel  Signals                                  Moves
//  -------  ---------------------------------------  ------------------------
//  pixel    pixel_valid / pixel_ready / pixel        one pixel request in
//  point    point_valid / point_ready / point        one world point out
//  config   psel penable pwrite paddr pwdata prdata  register write / read
//
// Seven pipeline stages; a passing pixel reaches point through the stage
// registers in order. One pixel enters per clock while the output is not stalled,
// as the multiplier chain (ray, depth scale, rotation) is split by registers.
// Pixels whose depth fails the floor/ceiling window leave at stage 1 and
// give no point. Reset clears every stage valid bit and loads the register
// defaults. Each stage holds while the next one is full and holding; empty
// stages close up, so pixels keep entering while a point waits.
//
`include "equirect_depth_unproject_core_assert.svh"

module equirect_depth_unproject_core #(
	parameter int PANO_WIDTH  = eqdu_pkg::PANO_WIDTH_DEF,
	parameter int PANO_HEIGHT = eqdu_pkg::PANO_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [eqdu_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [eqdu_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [eqdu_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	// pixel requests
	input  logic                            pixel_valid,
	output logic                            pixel_ready,
	input  eqdu_pkg::pixel_t                pixel,
	// world points
	output logic                            point_valid,
	input  logic                            point_ready,
	output eqdu_pkg::point_t                point
);
	import eqdu_pkg::*;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [ROT_W-1:0]          rot_q [3];
	logic signed [WORLD_W-1:0] trans_q [3];
	logic [DEPTH_W-1:0]        depth_floor_q;
	logic [DEPTH_W-1:0]        depth_ceil_q;
	logic                      cfg_wr;
	cfg_reg_t                  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				rot_q[a]   <= '0;
				trans_q[a] <= '0;
			end
			depth_floor_q <= DEPTH_FLOOR_RST;
			depth_ceil_q  <= DEPTH_CEIL_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ROT_X:       rot_q[0]      <= pwdata[ROT_W-1:0];
				REG_ROT_Y:       rot_q[1]      <= pwdata[ROT_W-1:0];
				REG_ROT_Z:       rot_q[2]      <= pwdata[ROT_W-1:0];
				REG_TRANS_X:     trans_q[0]    <= pwdata[WORLD_W-1:0];
				REG_TRANS_Y:     trans_q[1]    <= pwdata[WORLD_W-1:0];
				REG_TRANS_Z:     trans_q[2]    <= pwdata[WORLD_W-1:0];
				REG_DEPTH_FLOOR: depth_floor_q <= pwdata[DEPTH_W-1:0];
				REG_DEPTH_CEIL:  depth_ceil_q  <= pwdata[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back, zero-extended to the bus
	always_comb begin
		unique case (cfg_idx)
			REG_ROT_X:       prdata = CFG_DATA_W'(rot_q[0]);
			REG_ROT_Y:       prdata = CFG_DATA_W'(rot_q[1]);
			REG_ROT_Z:       prdata = CFG_DATA_W'(rot_q[2]);
			REG_TRANS_X:     prdata = {{(CFG_DATA_W-WORLD_W){1'b0}}, trans_q[0]};
			REG_TRANS_Y:     prdata = {{(CFG_DATA_W-WORLD_W){1'b0}}, trans_q[1]};
			REG_TRANS_Z:     prdata = {{(CFG_DATA_W-WORLD_W){1'b0}}, trans_q[2]};
			REG_DEPTH_FLOOR: prdata = CFG_DATA_W'(depth_floor_q);
			REG_DEPTH_CEIL:  prdata = CFG_DATA_W'(depth_ceil_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Pipeline control: stage i advances when empty or when i+1 advances
	// ---------------------------------------------------------------
	logic [NUM_STAGES:1] stage_vld_q;
	logic [NUM_STAGES:1] stage_en;
	logic                depth_pass;

	always_comb begin
		stage_en[NUM_STAGES] = !stage_vld_q[NUM_STAGES] || point_ready;
		for (int i = NUM_STAGES - 1; i >= 1; i--) begin
			stage_en[i] = !stage_vld_q[i] || stage_en[i+1];
		end
	end

	assign pixel_ready = stage_en[1];
	assign depth_pass  = (pixel.depth > depth_floor_q) && (pixel.depth <= depth_ceil_q);

	// Drop rejected pixels right at entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_en[1]) begin
				stage_vld_q[1] <= pixel_valid && depth_pass;
			end
			for (int i = 2; i <= NUM_STAGES; i++) begin
				if (stage_en[i]) begin
					stage_vld_q[i] <= stage_vld_q[i-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Side band: depth, colour and splat travel beside the datapath
	// ---------------------------------------------------------------
	logic [DEPTH_W-1:0] depth_s1;
	color_t             color_q [1:NUM_STAGES];
	logic [SPLAT_W-1:0] splat_q [5:NUM_STAGES];
	logic [SPLAT_W-1:0] splat_s4;

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			depth_s1   <= pixel.depth;
			color_q[1] <= '{red: pixel.red, green: pixel.green, blue: pixel.blue};
		end
		for (int i = 2; i <= NUM_STAGES; i++) begin
			if (stage_en[i]) begin
				color_q[i] <= color_q[i-1];
			end
		end
		if (stage_en[5]) begin
			splat_q[5] <= splat_s4;
		end
		for (int i = 6; i <= NUM_STAGES; i++) begin
			if (stage_en[i]) begin
				splat_q[i] <= splat_q[i-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// Datapath
	// ---------------------------------------------------------------
	trig_t                     lon_s1;
	trig_t                     lat_s1;
	cam_t                      cam_s4;
	logic signed [WORLD_W-1:0] world_s7 [3];

	// Stage 1: table lookup
	eqdu_trig_rom #(
		.PANO_WIDTH  (PANO_WIDTH),
		.PANO_HEIGHT (PANO_HEIGHT)
	) u_trig_rom (
		.clk    (clk),
		.en     (stage_en[1]),
		.column (pixel.column),
		.row    (pixel.row),
		.lon_s1 (lon_s1),
		.lat_s1 (lat_s1)
	);

	// Stages 2-4: ray, depth scale, rounding
	eqdu_ray_scale u_ray_scale (
		.clk      (clk),
		.stage_en (stage_en[4:2]),
		.depth_s1 (depth_s1),
		.lon_s1   (lon_s1),
		.lat_s1   (lat_s1),
		.cam_s4   (cam_s4),
		.splat_s4 (splat_s4)
	);

	// Stages 5-7: rotate, translate, saturate; stage 7 is the output register
	eqdu_world_xform u_world_xform (
		.clk      (clk),
		.stage_en (stage_en[7:5]),
		.cam_s4   (cam_s4),
		.rot      (rot_q),
		.trans    (trans_q),
		.world_s7 (world_s7)
	);

	assign point_valid      = stage_vld_q[NUM_STAGES];
	assign point.world_x    = world_s7[0];
	assign point.world_y    = world_s7[1];
	assign point.world_z    = world_s7[2];
	assign point.splat_size = splat_q[NUM_STAGES];
	assign point.out_red    = color_q[NUM_STAGES].red;
	assign point.out_green  = color_q[NUM_STAGES].green;
	assign point.out_blue   = color_q[NUM_STAGES].blue;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`EQDU_ASSERT_NXT(a_reject_low, clk, arst_n,
		pixel_valid && pixel_ready && (pixel.depth <= depth_floor_q), !stage_vld_q[1])
	`EQDU_ASSERT_NXT(a_reject_high, clk, arst_n,
		pixel_valid && pixel_ready && (pixel.depth > depth_ceil_q), !stage_vld_q[1])
	`EQDU_ASSERT_IMP(a_full_stall, clk, arst_n,
		(&stage_vld_q) && !point_ready, !pixel_ready)
	`EQDU_ASSERT_IMP(a_splat_range, clk, arst_n,
		point_valid, point.splat_size <= SPLAT_MAX)

endmodule
